// ===== hw/rtl/selectable_string_hash_bucket_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the selectable string hash bucket
// Shared concurrent assertion forms used by the RTL modules.
// ----------------------------------------------------------------------------
`ifndef SELECTABLE_STRING_HASH_BUCKET_DEFINES_SVH
`define SELECTABLE_STRING_HASH_BUCKET_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SSHB_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define SSHB_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/sshb_pkg.sv =====
// ----------------------------------------------------------------------------
// sshb_pkg
// Types, codes and microcode tables for the selectable string hash bucket.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sshb_pkg;

    localparam int HASH_W  = 64;
    localparam int TSIZE_W = 32;
    localparam int SEL_W   = 4;
    localparam int STEP_W  = 3;
    localparam int SHAMT_W = 5;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_HASH_SELECT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE  = 1'd1;

    localparam logic [SEL_W-1:0]   HASH_SELECT_RST = 4'd1;
    localparam logic [TSIZE_W-1:0] TABLE_SIZE_RST  = 32'd65537;

    localparam logic [SEL_W-1:0] RULE_SHIFT_OR  = 4'd0;
    localparam logic [SEL_W-1:0] RULE_TIMES101  = 4'd1;
    localparam logic [SEL_W-1:0] RULE_DJB2      = 4'd2;
    localparam logic [SEL_W-1:0] RULE_FNV       = 4'd3;
    localparam logic [SEL_W-1:0] RULE_SDBM      = 4'd4;
    localparam logic [SEL_W-1:0] RULE_SAX       = 4'd5;
    localparam logic [SEL_W-1:0] RULE_SXOR      = 4'd6;
    localparam logic [SEL_W-1:0] RULE_BERNSTEIN = 4'd7;
    localparam logic [SEL_W-1:0] RULE_XBERN     = 4'd8;
    localparam logic [SEL_W-1:0] RULE_OAAT      = 4'd9;
    localparam logic [SEL_W-1:0] RULE_ELF       = 4'd10;

    localparam logic [HASH_W-1:0] DJB2_START = 64'd5381;
    localparam logic [HASH_W-1:0] FNV_START  = 64'd2166136261;
    localparam logic [HASH_W-1:0] ELF_MASK   = 64'h0000_0000_F000_0000;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } sshb_in_t;

    typedef struct packed {
        logic [HASH_W-1:0]  hash_value;
        logic [TSIZE_W-1:0] bucket_index;
    } sshb_out_t;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_SUB,
        OP_XOR,
        OP_OR,
        OP_AND,
        OP_ANDN
    } alu_op_t;

    typedef enum logic {
        X_H,
        X_A
    } x_sel_t;

    typedef enum logic [1:0] {
        B_C,
        B_A,
        B_H,
        B_MASK
    } b_sel_t;

    typedef enum logic {
        D_H,
        D_A
    } dst_t;

    typedef struct packed {
        alu_op_t            op;
        x_sel_t             xsel;
        logic               sh_right;
        logic [SHAMT_W-1:0] sh_amt;
        b_sel_t             bsel;
        dst_t               dst;
        logic               done;
    } uop_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FOLD,
        ST_FINISH,
        ST_DIV_START,
        ST_DIV,
        ST_DONE
    } state_t;

    function automatic logic [SEL_W-1:0] rule_of(input logic [SEL_W-1:0] sel);
        return (sel <= RULE_ELF) ? sel : RULE_TIMES101;
    endfunction

    function automatic logic [HASH_W-1:0] start_value(input logic [SEL_W-1:0] rule);
        logic [HASH_W-1:0] v;
        v = '0;
        if (rule == RULE_DJB2) begin
            v = DJB2_START;
        end else if (rule == RULE_FNV) begin
            v = FNV_START;
        end
        return v;
    endfunction

    function automatic uop_t mk(input alu_op_t op, input x_sel_t xs, input logic rt,
                                input int amt, input b_sel_t bs, input dst_t d,
                                input logic dn);
        uop_t u;
        u.op       = op;
        u.xsel     = xs;
        u.sh_right = rt;
        u.sh_amt   = SHAMT_W'(amt);
        u.bsel     = bs;
        u.dst      = d;
        u.done     = dn;
        return u;
    endfunction

    // per-byte fold sequences: h = running hash, a = scratch, c = sign-extended byte
    function automatic uop_t fold_uop(input logic [SEL_W-1:0] rule,
                                      input logic [STEP_W-1:0] step);
        uop_t u;
        u = mk(OP_OR, X_H, 1'b0, 5, B_C, D_H, 1'b1);
        case (rule)
            RULE_SHIFT_OR: begin
                u = mk(OP_OR, X_H, 1'b0, 5, B_C, D_H, 1'b1);
            end
            RULE_DJB2, RULE_BERNSTEIN: begin
                case (step)
                    3'd0: u = mk(OP_ADD, X_H, 1'b0, 5, B_C, D_A, 1'b0);
                    default: u = mk(OP_ADD, X_H, 1'b0, 0, B_A, D_H, 1'b1);
                endcase
            end
            RULE_FNV: begin
                case (step)
                    3'd0: u = mk(OP_ADD, X_H, 1'b0, 24, B_H, D_A, 1'b0);
                    3'd1: u = mk(OP_ADD, X_H, 1'b0, 8, B_A, D_A, 1'b0);
                    3'd2: u = mk(OP_ADD, X_H, 1'b0, 7, B_A, D_A, 1'b0);
                    3'd3: u = mk(OP_ADD, X_H, 1'b0, 4, B_A, D_A, 1'b0);
                    3'd4: u = mk(OP_ADD, X_H, 1'b0, 1, B_A, D_A, 1'b0);
                    default: u = mk(OP_XOR, X_A, 1'b0, 0, B_C, D_H, 1'b1);
                endcase
            end
            RULE_SDBM: begin
                case (step)
                    3'd0: u = mk(OP_ADD, X_H, 1'b0, 6, B_C, D_A, 1'b0);
                    3'd1: u = mk(OP_ADD, X_H, 1'b0, 16, B_A, D_A, 1'b0);
                    default: u = mk(OP_SUB, X_H, 1'b0, 0, B_A, D_H, 1'b1);
                endcase
            end
            RULE_SAX: begin
                case (step)
                    3'd0: u = mk(OP_ADD, X_H, 1'b0, 5, B_C, D_A, 1'b0);
                    3'd1: u = mk(OP_ADD, X_H, 1'b1, 2, B_A, D_A, 1'b0);
                    default: u = mk(OP_XOR, X_H, 1'b0, 0, B_A, D_H, 1'b1);
                endcase
            end
            RULE_SXOR: begin
                case (step)
                    3'd0: u = mk(OP_XOR, X_H, 1'b0, 4, B_C, D_A, 1'b0);
                    default: u = mk(OP_XOR, X_H, 1'b1, 28, B_A, D_H, 1'b1);
                endcase
            end
            RULE_XBERN: begin
                case (step)
                    3'd0: u = mk(OP_ADD, X_H, 1'b0, 5, B_H, D_A, 1'b0);
                    default: u = mk(OP_XOR, X_A, 1'b0, 0, B_C, D_H, 1'b1);
                endcase
            end
            RULE_OAAT: begin
                case (step)
                    3'd0: u = mk(OP_ADD, X_H, 1'b0, 0, B_C, D_H, 1'b0);
                    3'd1: u = mk(OP_ADD, X_H, 1'b0, 10, B_H, D_H, 1'b0);
                    default: u = mk(OP_XOR, X_H, 1'b1, 6, B_H, D_H, 1'b1);
                endcase
            end
            RULE_ELF: begin
                case (step)
                    3'd0: u = mk(OP_ADD, X_H, 1'b0, 4, B_C, D_H, 1'b0);
                    3'd1: u = mk(OP_AND, X_H, 1'b0, 0, B_MASK, D_A, 1'b0);
                    3'd2: u = mk(OP_XOR, X_A, 1'b1, 24, B_H, D_H, 1'b0);
                    default: u = mk(OP_ANDN, X_A, 1'b0, 0, B_H, D_H, 1'b1);
                endcase
            end
            default: begin
                case (step)
                    3'd0: u = mk(OP_ADD, X_H, 1'b0, 6, B_C, D_A, 1'b0);
                    3'd1: u = mk(OP_ADD, X_H, 1'b0, 5, B_A, D_A, 1'b0);
                    3'd2: u = mk(OP_ADD, X_H, 1'b0, 2, B_A, D_A, 1'b0);
                    default: u = mk(OP_ADD, X_H, 1'b0, 0, B_A, D_H, 1'b1);
                endcase
            end
        endcase
        return u;
    endfunction

    // one-at-a-time finishing avalanche
    function automatic uop_t finish_uop(input logic [STEP_W-1:0] step);
        uop_t u;
        case (step)
            3'd0: u = mk(OP_ADD, X_H, 1'b0, 3, B_H, D_H, 1'b0);
            3'd1: u = mk(OP_XOR, X_H, 1'b1, 11, B_H, D_H, 1'b0);
            default: u = mk(OP_ADD, X_H, 1'b0, 15, B_H, D_H, 1'b1);
        endcase
        return u;
    endfunction

endpackage

// ===== hw/rtl/selectable_string_hash_bucket.sv =====
// ----------------------------------------------------------------------------
// selectable_string_hash_bucket
// Byte-serial string hash with eleven selectable rules and bucket remainder.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one name byte per transaction (data_byte, last_byte).
//   m_ channel: one transaction per name, on its last byte: 64-bit hash and
//   hash modulo table_size (0 when table_size is 0).
//   cfg channel: cfg_index 0 = hash_select, 1 = table_size; always ready,
//   write only while the block is idle.
//   Each byte passes through the shared shift/op unit: one capture, then 1 to
//   6 microcode steps set by the rule (one-at-a-time adds 3 finishing steps
//   on the last byte). The last byte then passes through the divide start, the
//   bit-serial remainder unit and the load of the output register. s_ready is
//   high only between items.
//   If m_ready is low the result waits in the output register; the next name
//   can be folded meanwhile and stalls only at its own final load.
//   Reset (aresetn low, synchronous): hash_select = 1, table_size = 65537,
//   no name in progress, no result pending.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "selectable_string_hash_bucket_defines.svh"

module selectable_string_hash_bucket (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  sshb_pkg::sshb_in_t                   s_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output sshb_pkg::sshb_out_t                  m_data,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [sshb_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [sshb_pkg::CFG_DATA_W-1:0]      cfg_data
);

    sshb_pkg::state_t                 state_reg, state_next;
    logic [sshb_pkg::STEP_W-1:0]      step_reg, step_next;
    logic [sshb_pkg::SEL_W-1:0]       rule_reg, rule_next;
    logic                             last_reg, last_next;
    logic                             in_name_reg, in_name_next;
    logic [sshb_pkg::SEL_W-1:0]       hash_select_reg, hash_select_next;
    logic [sshb_pkg::TSIZE_W-1:0]     table_size_reg, table_size_next;
    logic [sshb_pkg::HASH_W-1:0]      h_reg, h_next;
    logic [sshb_pkg::HASH_W-1:0]      a_reg, a_next;
    logic [sshb_pkg::HASH_W-1:0]      c_reg, c_next;
    logic                             m_valid_reg, m_valid_next;
    sshb_pkg::sshb_out_t              out_reg, out_next;

    sshb_pkg::uop_t                   uop;
    logic [sshb_pkg::HASH_W-1:0]      alu_res;
    logic [sshb_pkg::SEL_W-1:0]       sel_rule;
    logic                             s_fire;
    logic                             alu_en;
    logic                             div_start;
    logic                             div_done;
    logic [sshb_pkg::TSIZE_W-1:0]     div_rem;

    assign s_fire   = s_valid && s_ready;
    assign sel_rule = sshb_pkg::rule_of(hash_select_reg);
    assign uop      = (state_reg == sshb_pkg::ST_FINISH) ? sshb_pkg::finish_uop(step_reg)
                                                         : sshb_pkg::fold_uop(rule_reg, step_reg);

    sshb_alu u_alu (
        .uop    (uop),
        .h_val  (h_reg),
        .a_val  (a_reg),
        .c_val  (c_reg),
        .result (alu_res)
    );

    sshb_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (h_reg),
        .divisor   (table_size_reg),
        .done      (div_done),
        .remainder (div_rem)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            sshb_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = sshb_pkg::ST_FOLD;
                end
            end
            sshb_pkg::ST_FOLD: begin
                if (uop.done) begin
                    if (!last_reg) begin
                        state_next = sshb_pkg::ST_IDLE;
                    end else if (rule_reg == sshb_pkg::RULE_OAAT) begin
                        state_next = sshb_pkg::ST_FINISH;
                    end else begin
                        state_next = sshb_pkg::ST_DIV_START;
                    end
                end
            end
            sshb_pkg::ST_FINISH: begin
                if (uop.done) begin
                    state_next = sshb_pkg::ST_DIV_START;
                end
            end
            sshb_pkg::ST_DIV_START: begin
                state_next = sshb_pkg::ST_DIV;
            end
            sshb_pkg::ST_DIV: begin
                if (div_done) begin
                    state_next = sshb_pkg::ST_DONE;
                end
            end
            sshb_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = sshb_pkg::ST_IDLE;
                end
            end
            default: state_next = sshb_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_ready   = 1'b0;
        alu_en    = 1'b0;
        div_start = 1'b0;
        case (state_reg)
            sshb_pkg::ST_IDLE:      s_ready   = 1'b1;
            sshb_pkg::ST_FOLD:      alu_en    = 1'b1;
            sshb_pkg::ST_FINISH:    alu_en    = 1'b1;
            sshb_pkg::ST_DIV_START: div_start = 1'b1;
            default: begin
            end
        endcase
    end

    // datapath
    always_comb begin
        step_next        = step_reg;
        rule_next        = rule_reg;
        last_next        = last_reg;
        in_name_next     = in_name_reg;
        hash_select_next = hash_select_reg;
        table_size_next  = table_size_reg;
        h_next           = h_reg;
        a_next           = a_reg;
        c_next           = c_reg;
        m_valid_next     = m_valid_reg;
        out_next         = out_reg;

        if (cfg_valid) begin
            case (cfg_index)
                sshb_pkg::CFG_HASH_SELECT: hash_select_next = cfg_data[sshb_pkg::SEL_W-1:0];
                sshb_pkg::CFG_TABLE_SIZE:  table_size_next  = cfg_data[sshb_pkg::TSIZE_W-1:0];
                default: begin
                end
            endcase
        end

        if (s_fire) begin
            rule_next = sel_rule;
            last_next = s_data.last_byte;
            c_next    = {{(sshb_pkg::HASH_W-8){s_data.data_byte[7]}}, s_data.data_byte};
            h_next    = in_name_reg ? h_reg : sshb_pkg::start_value(sel_rule);
            step_next = '0;
        end

        if (alu_en) begin
            if (uop.dst == sshb_pkg::D_A) begin
                a_next = alu_res;
            end else begin
                h_next = alu_res;
            end
            step_next = uop.done ? '0 : step_reg + 1'b1;
            if (uop.done && state_reg == sshb_pkg::ST_FOLD) begin
                in_name_next = !last_reg;
            end
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (state_reg == sshb_pkg::ST_DONE && (!m_valid_reg || m_ready)) begin
            m_valid_next          = 1'b1;
            out_next.hash_value   = h_reg;
            out_next.bucket_index = (table_size_reg == '0) ? '0 : div_rem;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= sshb_pkg::ST_IDLE;
            step_reg        <= '0;
            in_name_reg     <= 1'b0;
            hash_select_reg <= sshb_pkg::HASH_SELECT_RST;
            table_size_reg  <= sshb_pkg::TABLE_SIZE_RST;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            step_reg        <= step_next;
            in_name_reg     <= in_name_next;
            hash_select_reg <= hash_select_next;
            table_size_reg  <= table_size_next;
            m_valid_reg     <= m_valid_next;
        end
        rule_reg <= rule_next;
        last_reg <= last_next;
        h_reg    <= h_next;
        a_reg    <= a_next;
        c_reg    <= c_next;
        out_reg  <= out_next;
    end

    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = out_reg;

    `SSHB_ASSERT_NEXT(a_accept_folds, aclk, aresetn, s_fire,
        state_reg == sshb_pkg::ST_FOLD, "accepted byte did not enter fold")
    `SSHB_ASSERT_NOW(a_div_done_state, aclk, aresetn, div_done,
        state_reg == sshb_pkg::ST_DIV, "remainder finished outside divide state")
    `SSHB_ASSERT_NOW(a_bucket_range, aclk, aresetn, $rose(m_valid_reg),
        (table_size_reg == '0) || (out_reg.bucket_index < table_size_reg),
        "bucket index not below table size")
    `SSHB_ASSERT_NOW(a_finish_oaat, aclk, aresetn, state_reg == sshb_pkg::ST_FINISH,
        rule_reg == sshb_pkg::RULE_OAAT, "finish steps on a rule without them")

endmodule

// ===== hw/rtl/sshb_alu.sv =====
// ----------------------------------------------------------------------------
// sshb_alu
// Shared shift-and-operate unit: result = op(shift(x), b) on 64-bit words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sshb_alu (
    input  sshb_pkg::uop_t                uop,
    input  logic [sshb_pkg::HASH_W-1:0]   h_val,
    input  logic [sshb_pkg::HASH_W-1:0]   a_val,
    input  logic [sshb_pkg::HASH_W-1:0]   c_val,
    output logic [sshb_pkg::HASH_W-1:0]   result
);

    logic [sshb_pkg::HASH_W-1:0] x_val;
    logic [sshb_pkg::HASH_W-1:0] sx_val;
    logic [sshb_pkg::HASH_W-1:0] b_val;

    always_comb begin
        x_val = (uop.xsel == sshb_pkg::X_A) ? a_val : h_val;
        sx_val = uop.sh_right ? (x_val >> uop.sh_amt) : (x_val << uop.sh_amt);
        case (uop.bsel)
            sshb_pkg::B_C:    b_val = c_val;
            sshb_pkg::B_A:    b_val = a_val;
            sshb_pkg::B_H:    b_val = h_val;
            sshb_pkg::B_MASK: b_val = sshb_pkg::ELF_MASK;
            default:          b_val = c_val;
        endcase
    end

    always_comb begin
        case (uop.op)
            sshb_pkg::OP_ADD:  result = sx_val + b_val;
            sshb_pkg::OP_SUB:  result = b_val - sx_val;
            sshb_pkg::OP_XOR:  result = sx_val ^ b_val;
            sshb_pkg::OP_OR:   result = sx_val | b_val;
            sshb_pkg::OP_AND:  result = sx_val & b_val;
            sshb_pkg::OP_ANDN: result = b_val & ~sx_val;
            default:           result = sx_val + b_val;
        endcase
    end

endmodule

// ===== hw/rtl/sshb_div.sv =====
// ----------------------------------------------------------------------------
// sshb_div
// Restoring 64-by-32 remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "selectable_string_hash_bucket_defines.svh"

module sshb_div (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [sshb_pkg::HASH_W-1:0]    dividend,
    input  logic [sshb_pkg::TSIZE_W-1:0]   divisor,
    output logic                           done,
    output logic [sshb_pkg::TSIZE_W-1:0]   remainder
);

    localparam int CNT_W = $clog2(sshb_pkg::HASH_W);

    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [CNT_W-1:0]               cnt_reg, cnt_next;
    logic [sshb_pkg::HASH_W-1:0]    dvd_reg, dvd_next;
    logic [sshb_pkg::TSIZE_W-1:0]   dvs_reg, dvs_next;
    logic [sshb_pkg::TSIZE_W-1:0]   rem_reg, rem_next;
    logic [sshb_pkg::TSIZE_W:0]     trial;
    logic [sshb_pkg::TSIZE_W:0]     diff;

    always_comb begin
        trial      = {rem_reg, dvd_reg[sshb_pkg::HASH_W-1]};
        diff       = trial - {1'b0, dvs_reg};
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        dvd_next   = dvd_reg;
        dvs_next   = dvs_reg;
        rem_next   = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            dvs_next  = divisor;
            rem_next  = '0;
        end else if (busy_reg) begin
            dvd_next = dvd_reg << 1;
            rem_next = (trial >= {1'b0, dvs_reg}) ? diff[sshb_pkg::TSIZE_W-1:0]
                                                  : trial[sshb_pkg::TSIZE_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(sshb_pkg::HASH_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

    `SSHB_ASSERT_NOW(a_div_start_idle, aclk, aresetn, start, !busy_reg, "div start while busy")
    `SSHB_ASSERT_NOW(a_div_done_idle, aclk, aresetn, done_reg, !busy_reg, "div done while busy")
    `SSHB_ASSERT_NOW(a_div_rem_range, aclk, aresetn, busy_reg && !start,
        (dvs_reg == '0) || (rem_reg < dvs_reg), "partial remainder out of range")

endmodule

// ===== bench/selectable_string_hash_bucket_tb.sv =====
// ----------------------------------------------------------------------------
// selectable_string_hash_bucket_tb
// Streams name bytes through the hash block under all eleven rules, odd
// selector values and a range of table sizes, and checks every hash and
// bucket index against a cycle-free prediction. Both channels idle in random
// bursts, and one long output hold-off fills the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module selectable_string_hash_bucket_tb;

    localparam int SETTLE_CYCLES = 120;

    logic                                aclk = 1'b0;
    logic                                aresetn = 1'b0;
    logic                                s_valid = 1'b0;
    logic                                s_ready;
    sshb_pkg::sshb_in_t                  s_data = '0;
    logic                                m_valid;
    logic                                m_ready = 1'b0;
    sshb_pkg::sshb_out_t                 m_data;
    logic                                cfg_valid = 1'b0;
    logic                                cfg_ready;
    logic [sshb_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
    logic [sshb_pkg::CFG_DATA_W-1:0]     cfg_data = '0;

    sshb_pkg::sshb_out_t                 pending_digests[$];
    logic [sshb_pkg::SEL_W-1:0]          mdl_sel;
    logic [sshb_pkg::TSIZE_W-1:0]        mdl_tsize;
    logic [sshb_pkg::HASH_W-1:0]         mdl_hash;
    logic                                mdl_open;
    int                                  mismatches = 0;
    bit                                  bursty = 1'b1;
    int                                  backlog_hold = 0;

    selectable_string_hash_bucket i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Hash prediction
    // ------------------------------------------------------------------------
    function automatic logic [sshb_pkg::SEL_W-1:0] effective_rule(
            input logic [sshb_pkg::SEL_W-1:0] sel);
        return (sel > sshb_pkg::RULE_ELF) ? sshb_pkg::RULE_TIMES101 : sel;
    endfunction

    function automatic logic [sshb_pkg::HASH_W-1:0] seed_for(
            input logic [sshb_pkg::SEL_W-1:0] rule);
        if (rule == sshb_pkg::RULE_DJB2) return 64'd5381;
        if (rule == sshb_pkg::RULE_FNV) return 64'd2166136261;
        return '0;
    endfunction

    function automatic logic [sshb_pkg::HASH_W-1:0] mix_byte(
            input logic [sshb_pkg::SEL_W-1:0]  rule,
            input logic [sshb_pkg::HASH_W-1:0] h,
            input logic [sshb_pkg::HASH_W-1:0] c);
        logic [sshb_pkg::HASH_W-1:0] t;
        logic [sshb_pkg::HASH_W-1:0] g;
        case (rule)
            sshb_pkg::RULE_SHIFT_OR: begin
                t = (h << 5) | c;
            end
            sshb_pkg::RULE_DJB2, sshb_pkg::RULE_BERNSTEIN: begin
                t = (h << 5) + h + c;
            end
            sshb_pkg::RULE_FNV: begin
                t = (h * 64'd16777619) ^ c;
            end
            sshb_pkg::RULE_SDBM: begin
                t = c + (h << 6) + (h << 16) - h;
            end
            sshb_pkg::RULE_SAX: begin
                t = h ^ ((h << 5) + (h >> 2) + c);
            end
            sshb_pkg::RULE_SXOR: begin
                t = (h << 4) ^ (h >> 28) ^ c;
            end
            sshb_pkg::RULE_XBERN: begin
                t = (h * 64'd33) ^ c;
            end
            sshb_pkg::RULE_OAAT: begin
                t = h + c;
                t = t + (t << 10);
                t = t ^ (t >> 6);
            end
            sshb_pkg::RULE_ELF: begin
                t = (h << 4) + c;
                g = t & 64'h0000_0000_F000_0000;
                t = (t ^ (g >> 24)) & ~g;
            end
            default: begin
                t = h * 64'd101 + c;
            end
        endcase
        return t;
    endfunction

    function automatic logic [sshb_pkg::HASH_W-1:0] close_hash(
            input logic [sshb_pkg::SEL_W-1:0]  rule,
            input logic [sshb_pkg::HASH_W-1:0] h);
        logic [sshb_pkg::HASH_W-1:0] t;
        t = h;
        if (rule == sshb_pkg::RULE_OAAT) begin
            t = t + (t << 3);
            t = t ^ (t >> 11);
            t = t + (t << 15);
        end
        return t;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t ns  %s: got %h, expected %h", $time, what, got, want);
        mismatches++;
    endtask

    // predict on accepted bytes, check each result transaction in order
    always @(posedge aclk) begin : scoreboard
        logic [sshb_pkg::SEL_W-1:0]  rule;
        logic [sshb_pkg::HASH_W-1:0] h;
        sshb_pkg::sshb_out_t         want;
        if (!aresetn) begin
            mdl_sel   = sshb_pkg::HASH_SELECT_RST;
            mdl_tsize = sshb_pkg::TABLE_SIZE_RST;
            mdl_hash  = '0;
            mdl_open  = 1'b0;
            pending_digests.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == sshb_pkg::CFG_HASH_SELECT) begin
                    mdl_sel = cfg_data[sshb_pkg::SEL_W-1:0];
                end else begin
                    mdl_tsize = cfg_data;
                end
            end
            if (s_valid && s_ready) begin
                rule = effective_rule(mdl_sel);
                h = mdl_open ? mdl_hash : seed_for(rule);
                h = mix_byte(rule, h, {{56{s_data.data_byte[7]}}, s_data.data_byte});
                if (!s_data.last_byte) begin
                    mdl_hash = h;
                    mdl_open = 1'b1;
                end else begin
                    want.hash_value   = close_hash(rule, h);
                    want.bucket_index = (mdl_tsize == '0) ? '0 :
                        sshb_pkg::TSIZE_W'(want.hash_value % {32'd0, mdl_tsize});
                    pending_digests.push_back(want);
                    mdl_open = 1'b0;
                end
            end
            if (m_valid && m_ready) begin
                if (pending_digests.size() == 0) begin
                    report_mismatch("unexpected result", m_data.hash_value, '0);
                end else begin
                    want = pending_digests.pop_front();
                    if (m_data.hash_value !== want.hash_value)
                        report_mismatch("hash_value", m_data.hash_value, want.hash_value);
                    if (m_data.bucket_index !== want.bucket_index)
                        report_mismatch("bucket_index", {32'd0, m_data.bucket_index},
                                        {32'd0, want.bucket_index});
                end
            end
        end
    end

    // result sink: random stall bursts, plus one requested long hold-off
    initial begin : result_sink
        int k;
        @(posedge aclk);
        forever begin
            if (backlog_hold > 0) begin
                k = backlog_hold;
                backlog_hold = 0;
            end else if (bursty && $urandom_range(0, 5) == 0) begin
                k = $urandom_range(1, 12);
            end else begin
                k = 0;
            end
            if (k > 0) begin
                m_ready <= 1'b0;
                repeat (k) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] ch, input logic last);
        cfg_valid <= 1'b0;
        if (bursty && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= {ch, last};
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic write_reg(input logic [sshb_pkg::CFG_IDX_W-1:0] idx,
                             input logic [sshb_pkg::CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic settle();
        s_valid   <= 1'b0;
        cfg_valid <= 1'b0;
        while (pending_digests.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [7:0] any_char();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h80;
            3: return 8'h7F;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] any_table_size();
        case ($urandom_range(0, 7))
            0: return 32'd0;
            1: return 32'd1;
            2: return 32'hFFFF_FFFF;
            3: return 32'($urandom_range(2, 100));
            4: return 32'd65537;
            default: return $urandom;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_reset_defaults();
        send_byte(8'h7F, 1'b0);
        send_byte(8'h80, 1'b1);
        settle();
    endtask

    task automatic test_each_rule();
        for (int r = 0; r <= 10; r++) begin
            write_reg(sshb_pkg::CFG_HASH_SELECT, 32'(r));
            send_byte((r % 2) ? 8'hFF : 8'h81, 1'b1);
            settle();
        end
        write_reg(sshb_pkg::CFG_HASH_SELECT, 32'd11);
        send_byte(8'h01, 1'b1);
        settle();
        write_reg(sshb_pkg::CFG_HASH_SELECT, 32'd15);
        send_byte(8'hC3, 1'b1);
        settle();
    endtask

    task automatic test_table_extremes();
        write_reg(sshb_pkg::CFG_HASH_SELECT, {28'd0, sshb_pkg::RULE_FNV});
        write_reg(sshb_pkg::CFG_TABLE_SIZE, 32'd0);
        send_byte(8'h5A, 1'b1);
        settle();
        write_reg(sshb_pkg::CFG_TABLE_SIZE, 32'd1);
        send_byte(8'hA5, 1'b1);
        settle();
        write_reg(sshb_pkg::CFG_TABLE_SIZE, 32'hFFFF_FFFF);
        send_byte(8'hFE, 1'b1);
        settle();
    endtask

    // selector change while a name is open continues from the running hash
    task automatic test_rule_switch_mid_name();
        write_reg(sshb_pkg::CFG_HASH_SELECT, {28'd0, sshb_pkg::RULE_OAAT});
        send_byte(8'h00, 1'b0);
        send_byte(8'h9C, 1'b0);
        settle();
        write_reg(sshb_pkg::CFG_HASH_SELECT, {28'd0, sshb_pkg::RULE_ELF});
        send_byte(8'h01, 1'b1);
        settle();
    endtask

    task automatic test_backpressure();
        write_reg(sshb_pkg::CFG_HASH_SELECT, {28'd0, sshb_pkg::RULE_SDBM});
        write_reg(sshb_pkg::CFG_TABLE_SIZE, 32'd997);
        backlog_hold = 300;
        repeat (6) begin
            if ($urandom_range(0, 1)) send_byte(any_char(), 1'b0);
            send_byte(any_char(), 1'b1);
        end
        settle();
    endtask

    task automatic test_random_names(input int budget);
        int sent;
        int len;
        logic [sshb_pkg::SEL_W-1:0] sel;
        sent = 0;
        while (sent < budget) begin
            settle();
            sel = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(11, 15))
                                              : 4'($urandom_range(0, 10));
            write_reg(sshb_pkg::CFG_HASH_SELECT, {28'($urandom), sel});
            if ($urandom_range(0, 1)) write_reg(sshb_pkg::CFG_TABLE_SIZE, any_table_size());
            repeat ($urandom_range(4, 10)) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24)
                                                  : $urandom_range(1, 8);
                for (int i = 0; i < len; i++) send_byte(any_char(), i == len - 1);
                sent += len;
            end
            // leave a name open across the next selector write
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 3)) begin
                    send_byte(any_char(), 1'b0);
                    sent++;
                end
            end
        end
        send_byte(any_char(), 1'b1);
        settle();
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_each_rule();
        test_table_extremes();
        test_rule_switch_mid_name();
        test_backpressure();
        test_random_names(1050);
        bursty = 1'b0;
        test_random_names(170);
        if (mismatches == 0) begin
            $display("selectable_string_hash_bucket: match");
        end else begin
            $display("selectable_string_hash_bucket: mismatch");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("selectable_string_hash_bucket: mismatch");
        $finish;
    end

endmodule
